// ===== rtl/core/bcdnr_pkg.sv =====
// Shared constants, step tables and helper functions of the binary to BCD converter.
package bcdnr_pkg;

  localparam int unsigned ADDER_WIDTH = 32;
  localparam int unsigned STEPS       = 20;
  localparam int unsigned NUMBER_W    = 17;
  localparam int unsigned DIGIT_BITS  = 19;  // 3 + 4 * 4 weight bits
  localparam logic [NUMBER_W-1:0] RANGE_LIMIT = 17'd79999;

  // Per-step addend, 32-bit two's complement words
  localparam logic [31:0] ADD_TABLE [STEPS] = '{
    32'hFFFF63C0, 32'h00004E20, 32'h00002710, 32'h000007D0, 32'h00000FA0,
    32'h000007D0, 32'h000003E8, 32'h000000C8, 32'h00000190, 32'h000000C8,
    32'h00000064, 32'h00000014, 32'h00000028, 32'h00000014, 32'h0000000A,
    32'h00000002, 32'h00000004, 32'h00000002, 32'h00000001, 32'h00000001
  };

  // Per-step mask of carry-word bits that are cleared before the XOR
  localparam logic [31:0] KEEP_TABLE [STEPS] = '{
    32'hFFFFFF80, 32'h00000000, 32'h00000000, 32'h00001890, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h000003E8, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000044, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h0000000A, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000001
  };

  // Side information that travels with the accumulator
  typedef struct packed {
    logic                  carry;   // carry word is all ones
    logic                  oor;     // input above range limit
    logic [DIGIT_BITS-1:0] digits;  // top digit in the high bits
  } side_t;

  // Sign-extend a table word to 64 bits; callers truncate to the adder width
  function automatic logic [63:0] widen(input logic [31:0] word);
    widen = {{32{word[31]}}, word};
  endfunction

  // Weight bit that a carry out sets at a given step; last step sets none
  function automatic logic [DIGIT_BITS-1:0] digit_mask(input int unsigned step);
    logic [DIGIT_BITS-1:0] m;
    m = '0;
    if (step < STEPS - 1) begin
      m = {{(DIGIT_BITS-1){1'b0}}, 1'b1} << (DIGIT_BITS - 1 - step);
    end
    digit_mask = m;
  endfunction

endpackage

// ===== rtl/core/bcdnr_stage.sv =====
// One pipeline stage: a single add-and-decide step with its holding register.
module bcdnr_stage #(
  parameter int unsigned ADDER_WIDTH = bcdnr_pkg::ADDER_WIDTH,
  parameter int unsigned STEP        = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  output logic                   rdy_o,
  input  logic [ADDER_WIDTH-1:0] acc_i,
  input  bcdnr_pkg::side_t       side_i,
  output logic                   vld_o,
  input  logic                   rdy_i,
  output logic [ADDER_WIDTH-1:0] acc_o,
  output bcdnr_pkg::side_t       side_o
);

  localparam logic [ADDER_WIDTH-1:0] ADD_C =
    ADDER_WIDTH'(bcdnr_pkg::widen(bcdnr_pkg::ADD_TABLE[STEP]));
  localparam logic [ADDER_WIDTH-1:0] KEEP_C =
    ADDER_WIDTH'(bcdnr_pkg::widen(bcdnr_pkg::KEEP_TABLE[STEP]));
  localparam logic [ADDER_WIDTH-1:0] CARRY_ADD_C = ~KEEP_C ^ ADD_C;
  localparam logic [bcdnr_pkg::DIGIT_BITS-1:0] DIGIT_C = bcdnr_pkg::digit_mask(STEP);

  logic                   vld_q, vld_d;
  logic [ADDER_WIDTH-1:0] acc_q, acc_d;
  bcdnr_pkg::side_t       side_q, side_d;
  logic [ADDER_WIDTH-1:0] addend;
  logic [ADDER_WIDTH:0]   sum;
  logic                   cout;
  logic                   load;

  // Take a new word when empty or when the next stage drains this one
  assign rdy_o = ~vld_q | rdy_i;
  assign load  = vld_i & rdy_o;

  // Add the step constant; a carry out wraps around and sets the step's weight bit, if it has one
  always_comb begin
    addend = side_i.carry ? CARRY_ADD_C : ADD_C;
    sum    = {1'b0, acc_i} + {1'b0, addend};
    cout   = sum[ADDER_WIDTH];
    acc_d  = cout ? (sum[ADDER_WIDTH-1:0] + ADDER_WIDTH'(1)) : sum[ADDER_WIDTH-1:0];
    side_d        = side_i;
    side_d.carry  = cout;
    side_d.digits = cout ? (side_i.digits | DIGIT_C) : side_i.digits;
  end

  assign vld_d = rdy_o ? vld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q  <= acc_d;
      side_q <= side_d;
    end
  end

  assign vld_o  = vld_q;
  assign acc_o  = acc_q;
  assign side_o = side_q;

endmodule

// ===== rtl/core/binary_to_bcd_nonrestoring_top.sv =====
// Top level of the pipelined non-restoring binary to BCD converter.
// Converts a 17-bit unsigned number into five decimal digits (the top digit
// has weights 4,2,1 only) and flags inputs above 79999, whose digits then carry
// no decimal meaning. Each of the twenty conversion steps is one register
// stage holding one add with end-around carry, so a word passes through every
// stage register in turn before it shows up on the output, and a new word can
// enter every cycle while the output is not stalled. Each stage accepts whenever
// it is empty or draining, so bubbles close up while the output is stalled and
// nothing is lost or repeated.
module binary_to_bcd_nonrestoring_top #(
  parameter int unsigned ADDER_WIDTH = bcdnr_pkg::ADDER_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // number[16:0], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // digit_ten_thousands[2:0], digit_thousands[6:3],
                                      // digit_hundreds[10:7], digit_tens[14:11],
                                      // digit_ones[18:15], out_of_range[19], zero fill
);

  localparam int unsigned STEPS = bcdnr_pkg::STEPS;
  localparam int unsigned NW    = bcdnr_pkg::NUMBER_W;

  logic                   vld_w  [STEPS+1];
  logic                   rdy_w  [STEPS+1];
  logic [ADDER_WIDTH-1:0] acc_w  [STEPS+1];
  bcdnr_pkg::side_t       side_w [STEPS+1];
  logic [NW-1:0]          number;

  // Seed the first stage: accumulator starts at the number, carry word clear
  assign number               = s_axis_tdata[NW-1:0];
  assign vld_w[0]             = s_axis_tvalid;
  assign s_axis_tready        = rdy_w[0];
  assign acc_w[0]             = {{(ADDER_WIDTH-NW){1'b0}}, number};
  assign side_w[0].carry      = 1'b0;
  assign side_w[0].oor        = number > bcdnr_pkg::RANGE_LIMIT;
  assign side_w[0].digits     = '0;

  // Twenty step stages in a chain
  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    bcdnr_stage #(
      .ADDER_WIDTH (ADDER_WIDTH),
      .STEP        (k)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_w[k]),
      .rdy_o  (rdy_w[k]),
      .acc_i  (acc_w[k]),
      .side_i (side_w[k]),
      .vld_o  (vld_w[k+1]),
      .rdy_i  (rdy_w[k+1]),
      .acc_o  (acc_w[k+1]),
      .side_o (side_w[k+1])
    );
  end

  // Drive the output word from the last stage
  assign rdy_w[STEPS]  = m_axis_tready;
  assign m_axis_tvalid = vld_w[STEPS];
  assign m_axis_tdata  = {4'b0000,
                          side_w[STEPS].oor,
                          side_w[STEPS].digits[3:0],
                          side_w[STEPS].digits[7:4],
                          side_w[STEPS].digits[11:8],
                          side_w[STEPS].digits[15:12],
                          side_w[STEPS].digits[18:16]};

endmodule
